@@ hw/rtl/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the sensor frame parser: the payload
// structs of the byte and result channels and the frame layout constants.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int COUNT_W       = 6;
  localparam int SUM_W         = 16;
  localparam int WORD_W        = 16;
  localparam int PAYLOAD_START = 4;
  localparam int PM25_WORD     = 1;

  localparam logic [7:0] HEAD_FIRST  = 8'h42;
  localparam logic [7:0] HEAD_SECOND = 8'h4d;

  localparam logic [1:0] STATUS_GOOD    = 2'd0;
  localparam logic [1:0] STATUS_BAD_HDR = 2'd1;
  localparam logic [1:0] STATUS_BAD_SUM = 2'd2;

  typedef logic [3:0] word_index_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       idle_gap;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]        status;
    word_index_t       word_index;
    logic [WORD_W-1:0] word_value;
    logic              pm25_changed;
    logic              last;
  } result_item_t;

  // verdict of a completed frame, valid for one cycle
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } frame_end_t;

endpackage

@@ hw/rtl/sfp_ram.sv @@
// ----------------------------------------------------------------------------
// sfp_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 13,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/sfp_collect.sv @@
// ----------------------------------------------------------------------------
// sfp_collect
// Byte side of the parser: counts frame position, keeps the running sum and
// header check, assembles payload words into the word RAM and reports the
// frame verdict on the last byte.
// ----------------------------------------------------------------------------
module sfp_collect #(
  parameter int FRAME_BYTES = 32,
  parameter int WORD_COUNT  = 13,
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  sfp_pkg::byte_item_t         item,
  output logic                        at_end,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [sfp_pkg::WORD_W-1:0]  wr_data,
  output sfp_pkg::frame_end_t         frame_end
);

  import sfp_pkg::*;

  localparam logic [COUNT_W-1:0] LAST_POS    = COUNT_W'(FRAME_BYTES - 1);
  localparam logic [COUNT_W-1:0] SUM_END     = COUNT_W'(FRAME_BYTES - 2);
  localparam logic [COUNT_W-1:0] PAY_START   = COUNT_W'(PAYLOAD_START);
  localparam logic [COUNT_W-1:0] PAY_END     = COUNT_W'(PAYLOAD_START + 2 * WORD_COUNT);

  logic [COUNT_W-1:0] byte_count;
  logic [SUM_W-1:0]   running_sum;
  logic               header_bad;
  logic [7:0]         high_byte_hold;
  logic [7:0]         checksum_high;

  logic [COUNT_W-1:0] pay_off;
  logic               in_payload;
  logic               header_bad_next;
  logic [SUM_W-1:0]   running_sum_next;
  logic               byte_take;

  assign byte_take  = take && !item.idle_gap;
  assign at_end     = (byte_count == LAST_POS);
  assign pay_off    = byte_count - PAY_START;
  assign in_payload = (byte_count >= PAY_START) && (byte_count < PAY_END);

  always_comb begin
    header_bad_next = header_bad
                    || ((byte_count == COUNT_W'(0)) && (item.rx_byte != HEAD_FIRST))
                    || ((byte_count == COUNT_W'(1)) && (item.rx_byte != HEAD_SECOND));
    running_sum_next = running_sum;
    if (byte_count < SUM_END) begin
      running_sum_next = running_sum + SUM_W'(item.rx_byte);
    end
  end

  // odd payload offset completes a word
  assign wr_en   = byte_take && in_payload && pay_off[0];
  assign wr_addr = pay_off[AW:1];
  assign wr_data = {high_byte_hold, item.rx_byte};

  always_comb begin
    frame_end.valid  = byte_take && at_end;
    frame_end.status = STATUS_GOOD;
    if (header_bad_next) begin
      frame_end.status = STATUS_BAD_HDR;
    end else if ({checksum_high, item.rx_byte} != running_sum) begin
      frame_end.status = STATUS_BAD_SUM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_sum    <= '0;
      header_bad     <= 1'b0;
      high_byte_hold <= '0;
      checksum_high  <= '0;
    end else if (take) begin
      if (item.idle_gap || at_end) begin
        byte_count  <= '0;
        running_sum <= '0;
        header_bad  <= 1'b0;
      end else begin
        byte_count  <= byte_count + COUNT_W'(1);
        running_sum <= running_sum_next;
        header_bad  <= header_bad_next;
        if (in_payload && !pay_off[0]) begin
          high_byte_hold <= item.rx_byte;
        end
        if (byte_count == SUM_END) begin
          checksum_high <= item.rx_byte;
        end
      end
    end
  end

endmodule

@@ hw/rtl/sfp_drain.sv @@
// ----------------------------------------------------------------------------
// sfp_drain
// Result side of the parser: on a good frame reads the PM2.5 word, updates
// the change flag, then reads every payload word from the RAM into the
// result register. A bad frame loads a single error result.
// ----------------------------------------------------------------------------
module sfp_drain #(
  parameter int WORD_COUNT = 13,
  localparam int AW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sfp_pkg::frame_end_t         frame_end,
  output logic                        idle,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [sfp_pkg::WORD_W-1:0]  rd_data,
  output logic                        result_valid,
  input  logic                        result_ready,
  output sfp_pkg::result_item_t       result_item
);

  import sfp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PM_RD  = 3'd1;
  localparam logic [2:0] ST_PM_CMP = 3'd2;
  localparam logic [2:0] ST_W_RD   = 3'd3;
  localparam logic [2:0] ST_W_LD   = 3'd4;

  localparam logic [AW-1:0] PM_ADDR  = AW'(PM25_WORD);
  localparam logic [AW-1:0] LAST_IDX = AW'(WORD_COUNT - 1);

  logic [2:0]        state;
  logic [AW-1:0]     idx;
  logic              changed;
  logic [WORD_W-1:0] previous_pm25;
  logic              slot_free;
  logic              result_load;

  assign idle      = (state == ST_IDLE);
  assign slot_free = !result_valid || result_ready;
  assign rd_en     = (state == ST_PM_RD) || ((state == ST_W_RD) && slot_free);
  assign rd_addr   = (state == ST_PM_RD) ? PM_ADDR : idx;

  // a new result enters the register at this edge
  assign result_load = ((state == ST_IDLE) && frame_end.valid
                        && (frame_end.status != STATUS_GOOD))
                     || (state == ST_W_LD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      changed       <= 1'b0;
      previous_pm25 <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (frame_end.valid) begin
            if (frame_end.status != STATUS_GOOD) begin
              result_item.status        <= frame_end.status;
              result_item.word_index    <= '0;
              result_item.word_value    <= '0;
              result_item.pm25_changed  <= 1'b0;
              result_item.last          <= 1'b1;
            end else begin
              idx     <= '0;
              changed <= 1'b0;
              state   <= (WORD_COUNT > PM25_WORD) ? ST_PM_RD : ST_W_RD;
            end
          end
        end
        ST_PM_RD: begin
          state <= ST_PM_CMP;
        end
        ST_PM_CMP: begin
          changed       <= (rd_data != previous_pm25);
          previous_pm25 <= rd_data;
          state         <= ST_W_RD;
        end
        ST_W_RD: begin
          // read only when the result register frees up at this edge
          if (slot_free) begin
            state <= ST_W_LD;
          end
        end
        ST_W_LD: begin
          result_item.status       <= STATUS_GOOD;
          result_item.word_index   <= word_index_t'(idx);
          result_item.word_value   <= rd_data;
          result_item.pm25_changed <= changed;
          result_item.last         <= (idx == LAST_IDX);
          if (idx == LAST_IDX) begin
            state <= ST_IDLE;
          end else begin
            idx   <= idx + AW'(1);
            state <= ST_W_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/sensor_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_parser_core
// Gathers fixed-length sensor frames from serial bytes, checks header and
// additive checksum, and streams out the payload words or an error result.
//
//   channel  direction  handshake                    payload
//   byte     in         byte_valid / byte_ready      byte_item   (byte_item_t)
//   result   out        result_valid / result_ready  result_item (result_item_t)
//
// Bytes and idle gaps are taken while no frame is being drained.
// A good frame holds off the byte channel while it drains, longer under
// any result stall: one RAM read for the PM2.5 word, then one read per word
// into the result register. A bad frame loads one result and does not stall.
// The last byte of a frame waits while a previous result is still unclaimed.
// Synchronous reset; no clearing pass, the word RAM needs no init.
// ----------------------------------------------------------------------------
module sensor_frame_parser_core #(
  parameter int FRAME_BYTES = 32,
  parameter int WORD_COUNT  = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  sfp_pkg::byte_item_t    byte_item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output sfp_pkg::result_item_t  result_item
);

  import sfp_pkg::*;

  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic              take;
  logic              at_end;
  logic              drain_idle;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  frame_end_t        frame_end;

  // frame end needs the result register free by the same edge
  assign byte_ready = drain_idle && (!at_end || !result_valid || result_ready);
  assign take       = byte_valid && byte_ready;

  sfp_collect #(
    .FRAME_BYTES (FRAME_BYTES),
    .WORD_COUNT  (WORD_COUNT)
  ) u_collect (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (byte_item),
    .at_end    (at_end),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .frame_end (frame_end)
  );

  sfp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORD_COUNT)
  ) u_words (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfp_drain #(
    .WORD_COUNT (WORD_COUNT)
  ) u_drain (
    .clk          (clk),
    .rst          (rst),
    .frame_end    (frame_end),
    .idle         (drain_idle),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

@@ hw/rtl/sfp_checker.sv @@
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks on the parser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sfp_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   byte_valid,
  input logic                   byte_ready,
  input sfp_pkg::byte_item_t    byte_item,
  input logic                   result_valid,
  input logic                   result_ready,
  input sfp_pkg::result_item_t  result_item
);

  import sfp_pkg::*;

  // a waiting byte transfer holds its payload
  a_byte_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_ready |=> byte_valid && $stable(byte_item))
    else $error("byte payload changed while waiting");

  // a stalled result transfer holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_item))
    else $error("result payload changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.status == STATUS_GOOD)
                  || (result_item.status == STATUS_BAD_HDR)
                  || (result_item.status == STATUS_BAD_SUM))
    else $error("undefined status code");

  // error results are single and carry no word
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.status != STATUS_GOOD)
      |-> result_item.last && (result_item.word_value == '0)
          && (result_item.word_index == '0) && !result_item.pm25_changed)
    else $error("malformed error result");

  // no byte is taken while a good frame is still draining
  a_drain_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.status == STATUS_GOOD) && !result_item.last
      |-> !byte_ready)
    else $error("byte accepted during frame drain");

endmodule

bind sensor_frame_parser_core sfp_checker u_sfp_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_ready   (byte_ready),
  .byte_item    (byte_item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_item  (result_item)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sensor_frame_parser_core. Builds sensor frames
// (good, repeated PM2.5, bad header, bad checksum, cut by a gap, noise) and
// streams them through the byte channel under several idle/stall mixes,
// predicting every result word and checking each result transfer in order.
// ----------------------------------------------------------------------------
module testbench;
  import sfp_pkg::*;

  localparam int FRAME_LEN   = 32;
  localparam int N_WORDS     = 13;
  localparam int PHASE_ITEMS = 50;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 100;

  typedef enum int {
    FRM_GOOD, FRM_SAME_PM25, FRM_BAD_HEAD, FRM_BAD_SUM, FRM_CUT, FRM_NOISE
  } frame_kind_e;

  logic         clk;
  logic         rst          = 1'b1;
  logic         byte_valid   = 1'b0;
  logic         byte_ready;
  byte_item_t   byte_item    = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_item_t result_item;

  sensor_frame_parser_core #(
    .FRAME_BYTES(FRAME_LEN),
    .WORD_COUNT (N_WORDS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_item (result_item)
  );

  byte_item_t   bytes_to_send[$];
  result_item_t frame_results_due[$];
  int           bytes_queued  = 0;
  int           bytes_taken   = 0;
  int           results_seen  = 0;
  int           errors        = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  logic [15:0]  last_good_pm25 = '0;

  // parser state mirrored on the bench side
  int          trk_count = 0;
  logic [15:0] trk_sum   = '0;
  logic        trk_head_bad = 1'b0;
  logic [7:0]  trk_hold  = '0;
  logic [7:0]  trk_csum_high = '0;
  logic [15:0] trk_words[N_WORDS];
  logic [15:0] trk_prev_pm25 = '0;

  int good_frames = 0;
  int head_errors = 0;
  int sum_errors  = 0;
  int dropped     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_failure(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      note_failure($sformatf("result %0d %s got %0h expected %0h",
                             results_seen, name, got, want));
  endtask

  task automatic track_frame_byte(input byte_item_t it);
    result_item_t r;
    logic [7:0]   b;
    logic [15:0]  check;
    logic         changed;
    int           off;
    b = it.rx_byte;
    if (it.idle_gap) begin
      if (trk_count != 0) dropped++;
      trk_count = 0;
      trk_sum = '0;
      trk_head_bad = 1'b0;
      return;
    end
    if ((trk_count == 0 && b != HEAD_FIRST) || (trk_count == 1 && b != HEAD_SECOND))
      trk_head_bad = 1'b1;
    if (trk_count < FRAME_LEN - 2) trk_sum = trk_sum + b;
    if (trk_count >= PAYLOAD_START && trk_count < PAYLOAD_START + 2 * N_WORDS) begin
      off = trk_count - PAYLOAD_START;
      if (off % 2 == 1) trk_words[off / 2] = {trk_hold, b};
      else trk_hold = b;
    end
    if (trk_count == FRAME_LEN - 2) trk_csum_high = b;
    if (trk_count + 1 < FRAME_LEN) begin
      trk_count++;
      return;
    end
    // frame end
    check = {trk_csum_high, b};
    r = '0;
    r.last = 1'b1;
    if (trk_head_bad) begin
      r.status = STATUS_BAD_HDR;
      frame_results_due.push_back(r);
      head_errors++;
    end else if (check != trk_sum) begin
      r.status = STATUS_BAD_SUM;
      frame_results_due.push_back(r);
      sum_errors++;
    end else begin
      changed = 1'b0;
      if (N_WORDS > PM25_WORD) begin
        changed = (trk_words[PM25_WORD] != trk_prev_pm25);
        trk_prev_pm25 = trk_words[PM25_WORD];
      end
      for (int i = 0; i < N_WORDS; i++) begin
        r.status       = STATUS_GOOD;
        r.word_index   = word_index_t'(i);
        r.word_value   = trk_words[i];
        r.pm25_changed = changed;
        r.last         = (i == N_WORDS - 1);
        frame_results_due.push_back(r);
      end
      good_frames++;
    end
    trk_count = 0;
    trk_sum = '0;
    trk_head_bad = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic gap);
    byte_item_t it;
    it.rx_byte  = b;
    it.idle_gap = gap;
    bytes_to_send.push_back(it);
    bytes_queued++;
  endtask

  // fill < 0 means random payload bytes
  task automatic queue_frame(input frame_kind_e kind, input int fill);
    logic [7:0]  fb[FRAME_LEN];
    logic [15:0] sum;
    logic [7:0]  flip;
    int          cut;
    int          pm_at;
    pm_at = PAYLOAD_START + 2 * PM25_WORD;
    if (kind == FRM_NOISE) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)), 1'b0);
      push_byte(8'($urandom_range(255)), 1'b1);
      return;
    end
    for (int i = 0; i < FRAME_LEN; i++)
      fb[i] = 8'((fill < 0) ? $urandom_range(255) : fill);
    fb[0] = HEAD_FIRST;
    fb[1] = HEAD_SECOND;
    if (kind == FRM_SAME_PM25) begin
      fb[pm_at]     = last_good_pm25[15:8];
      fb[pm_at + 1] = last_good_pm25[7:0];
    end
    flip = 8'($urandom_range(1, 255));
    if (kind == FRM_BAD_HEAD) begin
      if ($urandom_range(1)) fb[0] = HEAD_FIRST ^ flip;
      else fb[1] = HEAD_SECOND ^ flip;
    end
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 2; i++) sum = sum + fb[i];
    // header errors win even when the checksum is also off
    if (kind == FRM_BAD_SUM || (kind == FRM_BAD_HEAD && $urandom_range(1)))
      sum = sum ^ 16'($urandom_range(1, 65535));
    fb[FRAME_LEN - 2] = sum[15:8];
    fb[FRAME_LEN - 1] = sum[7:0];
    cut = (kind == FRM_CUT) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
    for (int i = 0; i < cut; i++) push_byte(fb[i], 1'b0);
    if (kind == FRM_CUT) push_byte(8'($urandom_range(255)), 1'b1);
    if (kind == FRM_GOOD || kind == FRM_SAME_PM25)
      last_good_pm25 = {fb[pm_at], fb[pm_at + 1]};
  endtask

  // byte channel driver
  always @(posedge clk) begin : drive_bytes
    byte_item_t nxt;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        track_frame_byte(byte_item);
        bytes_taken++;
      end
      if (!byte_valid || byte_ready) begin
        if (bytes_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = bytes_to_send.pop_front();
          byte_item  <= nxt;
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // result channel monitor
  always @(posedge clk) begin : watch_results
    result_item_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (frame_results_due.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = frame_results_due.pop_front();
          check_field("status", result_item.status, want.status);
          check_field("word_index", result_item.word_index, want.word_index);
          check_field("word_value", result_item.word_value, want.word_value);
          check_field("pm25_changed", result_item.pm25_changed, want.pm25_changed);
          check_field("last", result_item.last, want.last);
        end
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int          seq;
    int          start;
    int          fill;
    int          roll;
    int          waited;
    frame_kind_e kind;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // short edge cases: gaps with junk bytes, a header cut right away
    push_byte(8'hFF, 1'b1);
    push_byte(HEAD_FIRST, 1'b0);
    push_byte(HEAD_SECOND, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hAA, 1'b1);

    seq = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      start = bytes_queued;
      while (bytes_queued - start < PHASE_ITEMS) begin
        fill = -1;
        if (seq < 7) begin
          // walk every frame kind, good ones with all-ones and all-zeros payloads
          case (seq)
            0: begin kind = FRM_GOOD; fill = 8'hFF; end
            1: kind = FRM_SAME_PM25;
            2: begin kind = FRM_GOOD; fill = 8'h00; end
            3: kind = FRM_BAD_HEAD;
            4: kind = FRM_BAD_SUM;
            5: kind = FRM_CUT;
            default: kind = FRM_NOISE;
          endcase
        end else begin
          roll = $urandom_range(99);
          if (roll < 55) kind = FRM_GOOD;
          else if (roll < 65) kind = FRM_SAME_PM25;
          else if (roll < 75) kind = FRM_BAD_HEAD;
          else if (roll < 85) kind = FRM_BAD_SUM;
          else if (roll < 95) kind = FRM_CUT;
          else kind = FRM_NOISE;
          roll = $urandom_range(19);
          if (roll == 0) fill = 8'h00;
          else if (roll == 1) fill = 8'hFF;
        end
        queue_frame(kind, fill);
        seq++;
      end
      while (bytes_taken != bytes_queued) @(posedge clk);
    end

    waited = 0;
    while (frame_results_due.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frame_results_due.size() > 0)
      note_failure($sformatf("%0d results never arrived", frame_results_due.size()));

    $display("sent %0d bytes and gaps over 4 idle/stall mixes, %0d results checked",
             bytes_taken, results_seen);
    $display("frames: %0d good, %0d bad header, %0d bad checksum, %0d dropped by a gap",
             good_frames, head_errors, sum_errors, dropped);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_ram.sv
hw/rtl/sfp_collect.sv
hw/rtl/sfp_drain.sv
hw/rtl/sensor_frame_parser_core.sv
hw/rtl/sfp_checker.sv
verif/testbench.sv
